>>> rtl/core/pdsu_pkg.sv
// shared types and constants for the proper divisor sum unit
package pdsu_pkg;

   // fixed widths of the result fields
   localparam int COUNT_WIDTH   = 12;
   localparam int SUM_OUT_WIDTH = 34;

   // extra bits over the operand for a proper divisor sum (sum stays below 8x operand)
   localparam int SUM_HEADROOM  = 3;

   // status of the shared divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> rtl/core/pdsu_divider.sv
// shared restoring divider, one quotient bit per cycle
module pdsu_divider #(
   parameter int DATA_WIDTH = 34
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DATA_WIDTH-1:0]   dividend,
   input  logic [DATA_WIDTH-1:0]   divisor,
   output logic [DATA_WIDTH-1:0]   quotient,
   output logic [DATA_WIDTH-1:0]   remainder,
   output pdsu_pkg::div_stat_type  stat
);
   import pdsu_pkg::*;

   localparam int STEP_WIDTH = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] dsr_ff, dsr_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic                  active_ff, active_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;

   // partial remainder with next dividend bit, trial subtract
   assign shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   // load on start, then one restoring step per cycle
   always_comb begin
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      step_in   = step_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in    = '0;
         quo_in    = dividend;
         dsr_in    = divisor;
         step_in   = STEP_WIDTH'(DATA_WIDTH);
         active_in = 1'b1;
      end else if (active_ff) begin
         if (diff[DATA_WIDTH]) begin
            rem_in = shifted[DATA_WIDTH-1:0];
         end else begin
            rem_in = diff[DATA_WIDTH-1:0];
         end
         quo_in  = {quo_ff[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_WIDTH'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign stat.busy = active_ff;
   assign stat.done = done_ff;

endmodule

>>> rtl/core/proper_divisor_sum_unit_top.sv
// proper divisor sum unit: trial division sequencer around a shared divider
//
//  channel   ports                                   direction  handshake
//  request   start, busy, req_number                 in         start & !busy
//  response  rsp_strobe, rsp_divisor_count,          out        rsp_strobe, one cycle
//            rsp_divisor_sum, rsp_is_perfect,
//            rsp_is_amicable
//
// each trial candidate goes through a launch, NUMBER_WIDTH+3 divider steps,
// and a check; a candidate that divides evenly adds a hit step
// an item tries candidates up to about isqrt(n), then up to about isqrt(s), s the divisor sum,
// on the one bit per cycle divider shared by both passes
// busy stays high from the accepted item until the cycle before its result strobe
// synchronous reset clears the sequencer; the receiver cannot stall the result
module proper_divisor_sum_unit_top #(
   parameter int NUMBER_WIDTH = 31
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [NUMBER_WIDTH-1:0]              req_number,
   output logic                                 rsp_strobe,
   output logic [pdsu_pkg::COUNT_WIDTH-1:0]     rsp_divisor_count,
   output logic [pdsu_pkg::SUM_OUT_WIDTH-1:0]   rsp_divisor_sum,
   output logic                                 rsp_is_perfect,
   output logic                                 rsp_is_amicable
);
   import pdsu_pkg::*;

   localparam int SUM_WIDTH = NUMBER_WIDTH + SUM_HEADROOM;
   localparam int ACC_WIDTH = SUM_WIDTH + SUM_HEADROOM;
   localparam int EXT_WIDTH = (SUM_WIDTH > SUM_OUT_WIDTH) ? SUM_WIDTH : SUM_OUT_WIDTH;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LAUNCH = 2'd1;
   localparam logic [1:0] ST_WAIT   = 2'd2;
   localparam logic [1:0] ST_HIT    = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic                     pass_ff, pass_in;
   logic [NUMBER_WIDTH-1:0]  n_ff, n_in;
   logic [SUM_WIDTH-1:0]     dvd_ff, dvd_in;
   logic [SUM_WIDTH-1:0]     d_ff, d_in;
   logic [ACC_WIDTH-1:0]     acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [SUM_WIDTH-1:0]     sum1_ff, sum1_in;
   logic                     strobe_ff, strobe_in;
   logic [COUNT_WIDTH-1:0]   out_cnt_ff, out_cnt_in;
   logic [SUM_OUT_WIDTH-1:0] out_sum_ff, out_sum_in;
   logic                     perfect_ff, perfect_in;
   logic                     amicable_ff, amicable_in;

   logic                     div_start;
   logic [SUM_WIDTH-1:0]     div_quo;
   logic [SUM_WIDTH-1:0]     div_rem;
   div_stat_type             div_stat;

   logic                     is_root;
   logic                     pass_done;
   logic                     is_hit;
   logic [COUNT_WIDTH:0]     cnt_sum;
   logic [COUNT_WIDTH-1:0]   cnt_sat;
   logic [EXT_WIDTH-1:0]     sum_ext;
   logic [EXT_WIDTH-1:0]     sum_max_ext;
   logic [SUM_OUT_WIDTH-1:0] sum_clip;

   // shared divider: dividend / candidate
   pdsu_divider #(
      .DATA_WIDTH (SUM_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dvd_ff),
      .divisor   (d_ff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   // candidate checks on the divider result
   assign is_root   = (div_quo == d_ff);
   assign pass_done = (d_ff > div_quo);
   assign is_hit    = (div_rem == '0);

   // saturating divisor count
   assign cnt_sum = {1'b0, cnt_ff} + (is_root ? (COUNT_WIDTH + 1)'(1) : (COUNT_WIDTH + 1)'(2));
   assign cnt_sat = cnt_sum[COUNT_WIDTH] ? '1 : cnt_sum[COUNT_WIDTH-1:0];

   // saturating sum for the result port
   assign sum_ext     = EXT_WIDTH'(sum1_ff);
   assign sum_max_ext = EXT_WIDTH'({SUM_OUT_WIDTH{1'b1}});
   assign sum_clip    = (sum_ext > sum_max_ext) ? '1 : SUM_OUT_WIDTH'(sum1_ff);

   // sequencer: pass over the number, then over its divisor sum
   always_comb begin
      state_in    = state_ff;
      pass_in     = pass_ff;
      n_in        = n_ff;
      dvd_in      = dvd_ff;
      d_in        = d_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      sum1_in     = sum1_ff;
      strobe_in   = 1'b0;
      out_cnt_in  = out_cnt_ff;
      out_sum_in  = out_sum_ff;
      perfect_in  = perfect_ff;
      amicable_in = amicable_ff;
      div_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in     = req_number;
               dvd_in   = SUM_WIDTH'(req_number);
               d_in     = SUM_WIDTH'(2);
               acc_in   = ACC_WIDTH'(1);
               cnt_in   = COUNT_WIDTH'(1);
               pass_in  = 1'b0;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               if (pass_done) begin
                  if (!pass_ff) begin
                     // first pass finished: rescan its sum
                     sum1_in  = acc_ff[SUM_WIDTH-1:0];
                     dvd_in   = acc_ff[SUM_WIDTH-1:0];
                     d_in     = SUM_WIDTH'(2);
                     acc_in   = ACC_WIDTH'(1);
                     pass_in  = 1'b1;
                     state_in = ST_LAUNCH;
                  end else begin
                     // both passes finished: present the item
                     strobe_in   = 1'b1;
                     out_cnt_in  = cnt_ff;
                     out_sum_in  = sum_clip;
                     perfect_in  = (sum1_ff == SUM_WIDTH'(n_ff));
                     amicable_in = (acc_ff == ACC_WIDTH'(n_ff));
                     state_in    = ST_IDLE;
                  end
               end else if (is_hit) begin
                  // partner first, candidate next cycle
                  if (!is_root) begin
                     acc_in = acc_ff + ACC_WIDTH'(div_quo);
                  end
                  if (!pass_ff) begin
                     cnt_in = cnt_sat;
                  end
                  state_in = ST_HIT;
               end else begin
                  d_in     = d_ff + 1'b1;
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_HIT: begin
            acc_in   = acc_ff + ACC_WIDTH'(d_ff);
            d_in     = d_ff + 1'b1;
            state_in = ST_LAUNCH;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pass_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pass_ff   <= pass_in;
         strobe_ff <= strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      dvd_ff      <= dvd_in;
      d_ff        <= d_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      sum1_ff     <= sum1_in;
      out_cnt_ff  <= out_cnt_in;
      out_sum_ff  <= out_sum_in;
      perfect_ff  <= perfect_in;
      amicable_ff <= amicable_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_divisor_count = out_cnt_ff;
   assign rsp_divisor_sum   = out_sum_ff;
   assign rsp_is_perfect    = perfect_ff;
   assign rsp_is_amicable   = amicable_ff;

   // a perfect number is always reported amicable
   a_perfect_amicable: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_perfect |-> rsp_is_amicable)
      else $error("perfect item without amicable flag");

   // the count includes the divisor one
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_divisor_count != '0)
      else $error("result item with zero divisor count");

   // the divider only runs while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy || div_stat.done |-> state_ff == ST_WAIT)
      else $error("divider active outside wait state");

   // an accepted item makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted item did not start work");

endmodule
